### rtl/core/line_boundary_table_top_defines.svh
// Assertion macros for the line boundary table
`ifndef LINE_BOUNDARY_TABLE_TOP_DEFINES_SVH
`define LINE_BOUNDARY_TABLE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define LBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define LBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lbt_pkg.sv
// Shared types, command codes and constants of the line boundary table
`timescale 1ns / 1ps

package lbt_pkg;

  localparam int POS_BITS      = 24;
  localparam int MAX_LINES_DEF = 1024;
  localparam int CMD_W         = 3;
  localparam int CHAR_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int CELL_OP_W     = 3;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN_CHAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN_END  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LENGTHEN  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [CELL_OP_W-1:0] OP_NOP      = 3'd0;
  localparam logic [CELL_OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [CELL_OP_W-1:0] OP_SHIFT_DN = 3'd2;
  localparam logic [CELL_OP_W-1:0] OP_ADJUST   = 3'd3;
  localparam logic [CELL_OP_W-1:0] OP_SHIFT_UP = 3'd4;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    pos_t start;
    pos_t len;
  } entry_t;

  typedef struct packed {
    logic [CELL_OP_W-1:0] kind;
    pos_t                 delta;
    entry_t               wdata;
  } cell_op_t;

endpackage

### rtl/core/lbt_channels.sv
// Request and response channel interfaces of the line boundary table
`timescale 1ns / 1ps

interface lbt_req_if #(
  parameter int IDX_W = 10
);
  logic                       valid;
  logic                       ready;
  logic [lbt_pkg::CMD_W-1:0]  command;
  logic [lbt_pkg::CHAR_W-1:0] text_char;
  logic [IDX_W-1:0]           line_index;
  logic signed [lbt_pkg::POS_BITS-1:0] amount;
  logic [lbt_pkg::POS_BITS-1:0] new_length;

  modport source (output valid, command, text_char, line_index, amount, new_length,
                  input ready);
  modport sink (input valid, command, text_char, line_index, amount, new_length,
                output ready);
endinterface

interface lbt_rsp_if #(
  parameter int CNT_W = 11
);
  logic                         valid;
  logic                         ready;
  logic [lbt_pkg::POS_BITS-1:0] line_start;
  logic [lbt_pkg::POS_BITS-1:0] line_length;
  logic [CNT_W-1:0]             line_count;
  logic [lbt_pkg::STATUS_W-1:0] status;

  modport source (output valid, line_start, line_length, line_count, status,
                  input ready);
  modport sink (input valid, line_start, line_length, line_count, status,
                output ready);
endinterface

### rtl/core/line_boundary_table_top.sv
// Line boundary table: scan control, command sequencer and the cell row
// Indexed commands (read, remove, lengthen, insert) wait in S_WAIT while the registered
//   OR tree fetches the addressed entry out of the cell row; the others go straight to S_EXEC.
// One request at a time: ready only in S_IDLE, so a new request waits until the result
//   of the last is registered, and that can stall while out_rsp.ready is low.
// Reset: synchronous, active low; clears count, scan state and handshakes, not the cells.
`timescale 1ns / 1ps

`include "line_boundary_table_top_defines.svh"

module line_boundary_table_top #(
  parameter int MAX_LINES = lbt_pkg::MAX_LINES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lbt_req_if.sink          in_req,
  lbt_rsp_if.source        out_rsp
);

  localparam int IDX_W   = $clog2(MAX_LINES);
  localparam int CNT_W   = $clog2(MAX_LINES + 1);
  localparam int LVL     = IDX_W;
  localparam int LCNT_W  = $clog2(LVL + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [LCNT_W-1:0]            wcnt_r, wcnt_nxt;

  logic [lbt_pkg::CMD_W-1:0]    cmd_r;
  logic [lbt_pkg::CHAR_W-1:0]   char_r;
  logic [IDX_W-1:0]             idx_r;
  lbt_pkg::pos_t                amt_r;
  lbt_pkg::pos_t                nlen_r;

  logic [CNT_W-1:0]             count_r, count_nxt;
  lbt_pkg::pos_t                scan_start_r, scan_start_nxt;
  lbt_pkg::pos_t                scan_run_r, scan_run_nxt;
  logic                         scan_seen_r, scan_seen_nxt;

  logic                         out_valid_r;
  lbt_pkg::entry_t              out_ent_r, out_ent_nxt;
  logic [lbt_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0]             out_count_r;

  logic                         accept;
  logic                         indexed;
  logic                         fire;
  logic                         idx_ok;
  logic                         full;
  lbt_pkg::cell_op_t            op_c, op_w;
  logic [IDX_W-1:0]             pos_c;
  lbt_pkg::entry_t              hit;

  lbt_pkg::entry_t              ent_w [MAX_LINES];
  lbt_pkg::entry_t              rd_w  [MAX_LINES];

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign indexed      = (in_req.command == lbt_pkg::CMD_READ)
                     || (in_req.command == lbt_pkg::CMD_REMOVE)
                     || (in_req.command == lbt_pkg::CMD_LENGTHEN)
                     || (in_req.command == lbt_pkg::CMD_INSERT);
  assign fire         = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);
  assign idx_ok       = (CNT_W'(idx_r) < count_r);
  assign full         = (count_r == CNT_W'(MAX_LINES));

  always_comb begin
    state_nxt = state_r;
    wcnt_nxt  = wcnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = indexed ? S_WAIT : S_EXEC;
          wcnt_nxt  = '0;
        end
      end
      S_WAIT: begin
        wcnt_nxt = wcnt_r + 1'b1;
        if (wcnt_r == LCNT_W'(LVL)) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_c           = '0;
    op_c.kind      = lbt_pkg::OP_NOP;
    pos_c          = '0;
    count_nxt      = count_r;
    scan_start_nxt = scan_start_r;
    scan_run_nxt   = scan_run_r;
    scan_seen_nxt  = scan_seen_r;
    out_ent_nxt    = '0;
    out_status_nxt = lbt_pkg::ST_OK;
    case (cmd_r)
      lbt_pkg::CMD_CLEAR: begin
        count_nxt      = '0;
        scan_start_nxt = '0;
        scan_run_nxt   = '0;
        scan_seen_nxt  = 1'b0;
      end
      lbt_pkg::CMD_SCAN_CHAR: begin
        if (char_r == lbt_pkg::NEWLINE_CHAR) begin
          if (full) begin
            out_status_nxt = lbt_pkg::ST_FULL;
          end else begin
            op_c.kind        = lbt_pkg::OP_WRITE;
            op_c.wdata.start = scan_start_r;
            op_c.wdata.len   = scan_run_r;
            pos_c            = count_r[IDX_W-1:0];
            count_nxt        = count_r + 1'b1;
            scan_start_nxt   = scan_start_r + scan_run_r + 1'b1;
            scan_run_nxt     = '0;
            scan_seen_nxt    = 1'b1;
          end
        end else begin
          scan_run_nxt  = scan_run_r + 1'b1;
          scan_seen_nxt = 1'b1;
        end
      end
      lbt_pkg::CMD_SCAN_END: begin
        if (!scan_seen_r) begin
          if (full) begin
            out_status_nxt = lbt_pkg::ST_FULL;
          end else begin
            op_c.kind = lbt_pkg::OP_WRITE;
            pos_c     = count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
      end
      lbt_pkg::CMD_READ: begin
        if (!idx_ok) out_status_nxt = lbt_pkg::ST_RANGE;
        else out_ent_nxt = hit;
      end
      lbt_pkg::CMD_REMOVE: begin
        if (!idx_ok) begin
          out_status_nxt = lbt_pkg::ST_RANGE;
        end else begin
          op_c.kind  = lbt_pkg::OP_SHIFT_DN;
          op_c.delta = ~hit.len;
          pos_c      = idx_r;
          count_nxt  = count_r - 1'b1;
        end
      end
      lbt_pkg::CMD_LENGTHEN: begin
        if (!idx_ok) begin
          out_status_nxt = lbt_pkg::ST_RANGE;
        end else begin
          op_c.kind  = lbt_pkg::OP_ADJUST;
          op_c.delta = amt_r;
          pos_c      = idx_r;
        end
      end
      lbt_pkg::CMD_INSERT: begin
        if (!idx_ok) begin
          out_status_nxt = lbt_pkg::ST_RANGE;
        end else if (full) begin
          out_status_nxt = lbt_pkg::ST_FULL;
        end else begin
          op_c.kind        = lbt_pkg::OP_SHIFT_UP;
          op_c.delta       = nlen_r + 1'b1;
          op_c.wdata.start = hit.start + hit.len + 1'b1;
          op_c.wdata.len   = nlen_r;
          pos_c            = idx_r + 1'b1;
          count_nxt        = count_r + 1'b1;
        end
      end
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    op_w = op_c;
    if (!fire) op_w.kind = lbt_pkg::OP_NOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wcnt_r       <= '0;
      count_r      <= '0;
      scan_start_r <= '0;
      scan_run_r   <= '0;
      scan_seen_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      if (fire) begin
        count_r      <= count_nxt;
        scan_start_r <= scan_start_nxt;
        scan_run_r   <= scan_run_nxt;
        scan_seen_r  <= scan_seen_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_req.command;
      char_r <= in_req.text_char;
      idx_r  <= in_req.line_index;
      amt_r  <= lbt_pkg::pos_t'(in_req.amount);
      nlen_r <= in_req.new_length;
    end
    if (fire) begin
      out_ent_r    <= out_ent_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    lbt_pkg::entry_t prev_w;
    lbt_pkg::entry_t next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = ent_w[i-1];
    end
    if (i == MAX_LINES - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = ent_w[i+1];
    end
    lbt_cell #(
      .IDX_W   (IDX_W),
      .CELL_ID (i)
    ) u_cell (
      .clk      (clk),
      .op       (op_w),
      .pos      (pos_c),
      .rd_idx   (idx_r),
      .prev_ent (prev_w),
      .next_ent (next_w),
      .ent      (ent_w[i]),
      .rd_ent   (rd_w[i])
    );
  end

  lbt_tree #(
    .N_LEAF (MAX_LINES),
    .LVL    (LVL)
  ) u_tree (
    .clk    (clk),
    .leaves (rd_w),
    .root   (hit)
  );

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.line_start  = out_ent_r.start;
  assign out_rsp.line_length = out_ent_r.len;
  assign out_rsp.line_count  = out_count_r;
  assign out_rsp.status      = out_status_r;

  `LBT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_LINES), "count above table size")
  `LBT_ASSERT_NXT(a_count_hold, !fire, $stable(count_r), "count moved outside a request")
  `LBT_ASSERT_IMP(a_full_status, out_valid_r && out_status_r == lbt_pkg::ST_FULL, full, "room left")
  `LBT_ASSERT_NXT(a_idx_fetch, accept && indexed, state_r == S_WAIT, "no entry fetch")

endmodule

### rtl/core/lbt_cell.sv
// One table entry cell: holds start and length, shifts with its neighbors
`timescale 1ns / 1ps

module lbt_cell #(
  parameter int IDX_W   = 10,
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  lbt_pkg::cell_op_t op,
  input  logic [IDX_W-1:0]  pos,
  input  logic [IDX_W-1:0]  rd_idx,
  input  lbt_pkg::entry_t   prev_ent,
  input  lbt_pkg::entry_t   next_ent,
  output lbt_pkg::entry_t   ent,
  output lbt_pkg::entry_t   rd_ent
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  lbt_pkg::entry_t ent_r;
  lbt_pkg::entry_t ent_nxt;
  lbt_pkg::entry_t rd_r;
  logic            here;
  logic            after;

  assign here  = (pos == MY_IDX);
  assign after = (MY_IDX > pos);

  always_comb begin
    ent_nxt = ent_r;
    case (op.kind)
      lbt_pkg::OP_WRITE: begin
        if (here) ent_nxt = op.wdata;
      end
      lbt_pkg::OP_SHIFT_DN: begin
        if (here || after) begin
          ent_nxt.start = next_ent.start + op.delta;
          ent_nxt.len   = next_ent.len;
        end
      end
      lbt_pkg::OP_ADJUST: begin
        if (here) ent_nxt.len = ent_r.len + op.delta;
        else if (after) ent_nxt.start = ent_r.start + op.delta;
      end
      lbt_pkg::OP_SHIFT_UP: begin
        if (here) begin
          ent_nxt = op.wdata;
        end else if (after) begin
          ent_nxt.start = prev_ent.start + op.delta;
          ent_nxt.len   = prev_ent.len;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    rd_r  <= (rd_idx == MY_IDX) ? ent_r : '0;
  end

  assign ent    = ent_r;
  assign rd_ent = rd_r;

endmodule

### rtl/core/lbt_tree.sv
// Registered OR tree that gathers the one selected entry of the cell row
`timescale 1ns / 1ps

module lbt_tree #(
  parameter int N_LEAF = 1024,
  parameter int LVL    = 10
) (
  input  logic            clk,
  input  lbt_pkg::entry_t leaves [N_LEAF],
  output lbt_pkg::entry_t root
);

  localparam int NPOW = 2 ** LVL;

  lbt_pkg::entry_t leaf_w [NPOW];
  lbt_pkg::entry_t node_r [1:NPOW-1];

  for (genvar j = 0; j < NPOW; j++) begin : g_leaf
    if (j < N_LEAF) begin : g_used
      assign leaf_w[j] = leaves[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  for (genvar k = 1; k < NPOW; k++) begin : g_node
    if (2 * k >= NPOW) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[k] <= lbt_pkg::entry_t'(leaf_w[2*k-NPOW] | leaf_w[2*k+1-NPOW]);
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[k] <= lbt_pkg::entry_t'(node_r[2*k] | node_r[2*k+1]);
      end
    end
  end

  assign root = node_r[1];

endmodule

### tb/testbench.sv
// Self-checking testbench for the line boundary table: directed rows, random edits, full table
`timescale 1ns / 1ps

module testbench;
  import lbt_pkg::*;

  localparam int TABLE_DEPTH    = 1024;
  localparam int IDX_BITS       = 10;
  localparam int CNT_BITS       = 11;
  localparam int QUIET_LIMIT    = 2000;
  localparam int MIXED_REQUESTS = 150;
  localparam int TAIL_REQUESTS  = 80;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CHAR_W-1:0]   text_char;
    logic [IDX_BITS-1:0] line_index;
    pos_t                amount;
    pos_t                new_length;
  } table_request_t;

  typedef struct packed {
    pos_t                line_start;
    pos_t                line_length;
    logic [CNT_BITS-1:0] line_count;
    logic [STATUS_W-1:0] status;
  } table_reply_t;

  typedef struct packed {
    table_request_t req;
    logic           known;
    table_reply_t   reply;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  lbt_req_if #(.IDX_W(IDX_BITS)) req_bus ();
  lbt_rsp_if #(.CNT_W(CNT_BITS)) rsp_bus ();

  line_boundary_table_top #(.MAX_LINES(TABLE_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus.sink),
    .out_rsp (rsp_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pos_t         line_start_mem [TABLE_DEPTH];
  pos_t         line_len_mem [TABLE_DEPTH];
  int           table_count = 0;
  pos_t         scan_origin = '0;
  pos_t         scan_length = '0;
  logic         scan_any = 1'b0;
  table_reply_t pending_results[$];
  script_row_t  script[$];
  int           error_count = 0;
  int           send_calm = 0;
  int           sink_calm = 0;
  int           quiet_cycles = 0;

  function automatic table_reply_t apply_request(table_request_t r);
    table_reply_t res;
    pos_t         shift;
    int           idx;
    res = '0;
    idx = int'(r.line_index);
    case (r.command)
      CMD_CLEAR: begin
        table_count = 0;
        scan_origin = '0;
        scan_length = '0;
        scan_any = 1'b0;
      end
      CMD_SCAN_CHAR: begin
        if (r.text_char != NEWLINE_CHAR) begin
          scan_length = scan_length + 1'b1;
          scan_any = 1'b1;
        end else if (table_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          line_start_mem[table_count] = scan_origin;
          line_len_mem[table_count] = scan_length;
          table_count++;
          scan_origin = scan_origin + scan_length + 1'b1;
          scan_length = '0;
          scan_any = 1'b1;
        end
      end
      CMD_SCAN_END: begin
        if (!scan_any) begin
          if (table_count >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            line_start_mem[table_count] = '0;
            line_len_mem[table_count] = '0;
            table_count++;
          end
        end
      end
      CMD_READ: begin
        if (idx >= table_count) begin
          res.status = ST_RANGE;
        end else begin
          res.line_start = line_start_mem[idx];
          res.line_length = line_len_mem[idx];
        end
      end
      CMD_REMOVE: begin
        if (idx >= table_count) begin
          res.status = ST_RANGE;
        end else begin
          shift = line_len_mem[idx] + 1'b1;
          for (int i = idx; i < table_count - 1; i++) begin
            line_start_mem[i] = line_start_mem[i + 1];
            line_len_mem[i] = line_len_mem[i + 1];
          end
          table_count--;
          for (int i = idx; i < table_count; i++)
            line_start_mem[i] = line_start_mem[i] - shift;
        end
      end
      CMD_LENGTHEN: begin
        if (idx >= table_count) begin
          res.status = ST_RANGE;
        end else begin
          line_len_mem[idx] = line_len_mem[idx] + r.amount;
          for (int i = idx + 1; i < table_count; i++)
            line_start_mem[i] = line_start_mem[i] + r.amount;
        end
      end
      CMD_INSERT: begin
        if (idx >= table_count) begin
          res.status = ST_RANGE;
        end else if (table_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shift = r.new_length + 1'b1;
          for (int i = table_count; i > idx + 1; i--) begin
            line_start_mem[i] = line_start_mem[i - 1];
            line_len_mem[i] = line_len_mem[i - 1];
          end
          line_start_mem[idx + 1] = line_start_mem[idx] + line_len_mem[idx] + 1'b1;
          line_len_mem[idx + 1] = r.new_length;
          table_count++;
          for (int i = idx + 2; i < table_count; i++)
            line_start_mem[i] = line_start_mem[i] + shift;
        end
      end
      CMD_COUNT: begin
      end
      default: begin
      end
    endcase
    res.line_count = CNT_BITS'(table_count);
    return res;
  endfunction

  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic table_request_t random_request();
    table_request_t r;
    int             pick;
    r.text_char = ($urandom_range(0, 3) == 0) ? NEWLINE_CHAR : CHAR_W'($urandom_range(0, 255));
    r.line_index = IDX_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    if (table_count > 0 && $urandom_range(0, 99) < 85)
      r.line_index = IDX_BITS'($urandom_range(0, table_count - 1));
    r.amount = ($urandom_range(0, 1) != 0) ? pos_t'($urandom)
                                           : pos_t'(int'($urandom_range(0, 64)) - 32);
    r.new_length = ($urandom_range(0, 1) != 0) ? pos_t'($urandom)
                                               : pos_t'($urandom_range(0, 80));
    pick = $urandom_range(0, 99);
    if (pick < 3) r.command = CMD_CLEAR;
    else if (pick < 40) r.command = CMD_SCAN_CHAR;
    else if (pick < 45) r.command = CMD_SCAN_END;
    else if (pick < 60) r.command = CMD_READ;
    else if (pick < 70) r.command = CMD_REMOVE;
    else if (pick < 80) r.command = CMD_LENGTHEN;
    else if (pick < 92) r.command = CMD_INSERT;
    else r.command = CMD_COUNT;
    return r;
  endfunction

  function automatic table_request_t fill_request();
    table_request_t r;
    r = random_request();
    r.line_index = IDX_BITS'($urandom_range(0, table_count - 1));
    if ($urandom_range(0, 9) == 0)
      r.command = ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_LENGTHEN;
    else
      r.command = CMD_INSERT;
    return r;
  endfunction

  function automatic void plan_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch, int idx,
                                   pos_t amt, pos_t nlen);
    script_row_t row;
    row = '0;
    row.req = '{cmd, ch, IDX_BITS'(idx), amt, nlen};
    script = {script, row};
  endfunction

  function automatic void known_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch, int idx,
                                    pos_t start, pos_t len, int cnt,
                                    logic [STATUS_W-1:0] st);
    script_row_t row;
    row = '0;
    row.req = '{cmd, ch, IDX_BITS'(idx), 24'd0, 24'd0};
    row.known = 1'b1;
    row.reply = '{start, len, CNT_BITS'(cnt), st};
    script = {script, row};
  endfunction

  task automatic push_request(table_request_t r, logic known = 1'b0, table_reply_t reply = '0);
    int           gap;
    table_reply_t predicted;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.command    <= r.command;
    req_bus.text_char  <= r.text_char;
    req_bus.line_index <= r.line_index;
    req_bus.amount     <= r.amount;
    req_bus.new_length <= r.new_length;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    predicted = apply_request(r);
    pending_results = {pending_results, (known ? reply : predicted)};
  endtask

  task automatic run_script();
    for (int k = 0; k < script.size(); k++)
      push_request(script[k].req, script[k].known, script[k].reply);
    script.delete();
  endtask

  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_reply();
    table_reply_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: response with nothing outstanding: expected none, got %0h %0h %0d %0d",
               $time, rsp_bus.line_start, rsp_bus.line_length, rsp_bus.line_count,
               rsp_bus.status);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("line_start", 32'(want.line_start), 32'(rsp_bus.line_start));
    compare_field("line_length", 32'(want.line_length), 32'(rsp_bus.line_length));
    compare_field("line_count", 32'(want.line_count), 32'(rsp_bus.line_count));
    compare_field("status", 32'(want.status), 32'(rsp_bus.status));
  endtask

  initial begin : reply_sink
    int stall;
    rsp_bus.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_gap(sink_calm);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      check_reply();
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_bus.valid && req_bus.ready)
        || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("FAIL line_boundary_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : request_source
    req_bus.valid      <= 1'b0;
    req_bus.command    <= CMD_COUNT;
    req_bus.text_char  <= '0;
    req_bus.line_index <= '0;
    req_bus.amount     <= '0;
    req_bus.new_length <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    known_row(CMD_COUNT, 8'h00, 0, 24'd0, 24'd0, 0, ST_OK);
    known_row(CMD_READ, 8'h00, 0, 24'd0, 24'd0, 0, ST_RANGE);
    known_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0, 1, ST_OK);
    known_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0, 2, ST_OK);
    known_row(CMD_READ, 8'h00, 1, 24'd0, 24'd0, 2, ST_OK);
    known_row(CMD_CLEAR, 8'h00, 0, 24'd0, 24'd0, 0, ST_OK);
    plan_row(CMD_SCAN_CHAR, 8'h61, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, 8'hFF, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, NEWLINE_CHAR, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, 8'h00, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, NEWLINE_CHAR, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, 8'h7A, 0, 24'd0, 24'd0);
    known_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0, 2, ST_OK);
    known_row(CMD_READ, 8'h00, 1, 24'd3, 24'd1, 2, ST_OK);
    plan_row(CMD_LENGTHEN, 8'h00, 0, 24'h7FFFFF, 24'd0);
    plan_row(CMD_LENGTHEN, 8'h00, 1, 24'h800000, 24'd0);
    plan_row(CMD_READ, 8'h00, 1, 24'd0, 24'd0);
    plan_row(CMD_INSERT, 8'h00, 0, 24'd0, 24'hFFFFFF);
    plan_row(CMD_READ, 8'h00, 1, 24'd0, 24'd0);
    plan_row(CMD_READ, 8'h00, 2, 24'd0, 24'd0);
    plan_row(CMD_REMOVE, 8'h00, 0, 24'd0, 24'd0);
    plan_row(CMD_READ, 8'h00, 0, 24'd0, 24'd0);
    known_row(CMD_LENGTHEN, 8'h00, 1023, 24'd0, 24'd0, 2, ST_RANGE);
    known_row(CMD_REMOVE, 8'h00, 2, 24'd0, 24'd0, 2, ST_RANGE);
    known_row(CMD_INSERT, 8'h00, 2, 24'd0, 24'd0, 2, ST_RANGE);
    plan_row(CMD_INSERT, 8'h00, 1, 24'd0, 24'd0);
    plan_row(CMD_COUNT, 8'h00, 0, 24'd0, 24'd0);
    run_script();

    for (int n = 0; n < MIXED_REQUESTS; n++)
      push_request(random_request());
    hold_until_drained();

    plan_row(CMD_CLEAR, 8'h00, 0, 24'd0, 24'd0);
    plan_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0);
    run_script();
    while (table_count < TABLE_DEPTH)
      push_request(fill_request());

    known_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0, TABLE_DEPTH, ST_FULL);
    known_row(CMD_INSERT, 8'h00, 1023, 24'd0, 24'd0, TABLE_DEPTH, ST_FULL);
    known_row(CMD_SCAN_CHAR, NEWLINE_CHAR, 0, 24'd0, 24'd0, TABLE_DEPTH, ST_FULL);
    plan_row(CMD_READ, 8'h00, 1023, 24'd0, 24'd0);
    plan_row(CMD_SCAN_CHAR, 8'h41, 0, 24'd0, 24'd0);
    known_row(CMD_SCAN_CHAR, NEWLINE_CHAR, 0, 24'd0, 24'd0, TABLE_DEPTH, ST_FULL);
    known_row(CMD_SCAN_END, 8'h00, 0, 24'd0, 24'd0, TABLE_DEPTH, ST_OK);
    plan_row(CMD_LENGTHEN, 8'h00, 1023, 24'h800000, 24'd0);
    plan_row(CMD_READ, 8'h00, 1023, 24'd0, 24'd0);
    plan_row(CMD_REMOVE, 8'h00, 512, 24'd0, 24'd0);
    run_script();
    hold_until_drained();

    for (int n = 0; n < TAIL_REQUESTS; n++)
      push_request(random_request());

    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS line_boundary_table_top");
    else
      $display("FAIL line_boundary_table_top");
    $finish;
  end

endmodule
